// ===== rtl/core/nsc_pkg.sv =====
// Shared constants, types and register codes of the subsequence counter.
`default_nettype none
package nsc_pkg;

  localparam int unsigned MaxPatternDefault = 8;
  localparam int unsigned ByteW             = 8;
  localparam int unsigned CountW            = 63;
  localparam int unsigned PatternW          = 64;
  localparam int unsigned LenW              = 4;
  localparam int unsigned PDataW            = 64;
  localparam int unsigned PAddrW            = 4;
  localparam int unsigned PatternChars      = PatternW / ByteW;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
  localparam logic [CountW-1:0] CountOne = CountW'(1);

  typedef enum logic {
    RegPatternBytes  = 1'b0,
    RegPatternLength = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic step;
    logic clear;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/core/nsc_if.sv =====
// Stream interfaces for text bytes in and match counts out.
`default_nettype none
interface nsc_text_if;
  logic                       valid;
  logic                       ready;
  logic [nsc_pkg::ByteW-1:0]  text_byte;
  logic                       end_of_text;

  modport source (output valid, text_byte, end_of_text, input ready);
  modport sink   (input valid, text_byte, end_of_text, output ready);
endinterface

interface nsc_count_if;
  logic                       valid;
  logic                       ready;
  logic [nsc_pkg::CountW-1:0] match_count;
  logic                       final_flag;

  modport source (output valid, match_count, final_flag, input ready);
  modport sink   (input valid, match_count, final_flag, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/nsc_cfg.sv =====
// APB register file holding the pattern bytes and pattern length.
`default_nettype none
module nsc_cfg (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [nsc_pkg::PAddrW-1:0]   paddr,
  input  wire logic [nsc_pkg::PDataW-1:0]   pwdata,
  output logic      [nsc_pkg::PDataW-1:0]   prdata,
  output logic                              pready,
  output logic      [nsc_pkg::PatternW-1:0] pattern_bytes_o,
  output logic      [nsc_pkg::LenW-1:0]     pattern_length_o
);
  import nsc_pkg::*;

  logic [PatternW-1:0] pattern_bytes_q;
  logic [LenW-1:0]     pattern_length_q;
  reg_idx_e            idx;
  logic                wr_en;

  assign idx    = reg_idx_e'(paddr[PAddrW-1]);
  assign wr_en  = psel & penable & pwrite & pready;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_bytes_q  <= '0;
      pattern_length_q <= '0;
    end else if (wr_en) begin
      unique case (idx)
        RegPatternBytes:  pattern_bytes_q  <= pwdata[PatternW-1:0];
        RegPatternLength: pattern_length_q <= pwdata[LenW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegPatternBytes:  prdata = PDataW'(pattern_bytes_q);
      RegPatternLength: prdata = PDataW'(pattern_length_q);
      default:          prdata = '0;
    endcase
  end

  assign pattern_bytes_o  = pattern_bytes_q;
  assign pattern_length_o = pattern_length_q;

endmodule
`default_nettype wire

// ===== rtl/core/nsc_cell.sv =====
// One DP cell: counts for one pattern prefix length over the last two bytes.
`default_nettype none
module nsc_cell (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire nsc_pkg::cell_ctrl_t        ctrl_i,
  input  wire logic [nsc_pkg::ByteW-1:0]  byte_i,
  input  wire logic [nsc_pkg::ByteW-1:0]  char_i,
  input  wire logic [nsc_pkg::CountW-1:0] left_bp_i,
  output logic      [nsc_pkg::CountW-1:0] next_o,
  output logic      [nsc_pkg::CountW-1:0] bp_o
);
  import nsc_pkg::*;

  logic [CountW-1:0] prev_q, prev_d;
  logic [CountW-1:0] bp_q, bp_d;
  logic [CountW:0]   sum;
  logic [CountW-1:0] sat;

  // saturating add of the left neighbour's count from two bytes back
  assign sum    = {1'b0, prev_q} + {1'b0, left_bp_i};
  assign sat    = sum[CountW] ? CountMax : sum[CountW-1:0];
  assign next_o = (byte_i == char_i) ? sat : prev_q;

  always_comb begin
    prev_d = prev_q;
    bp_d   = bp_q;
    if (ctrl_i.clear) begin
      prev_d = '0;
      bp_d   = '0;
    end else if (ctrl_i.step) begin
      prev_d = next_o;
      bp_d   = prev_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      bp_q   <= '0;
    end else begin
      prev_q <= prev_d;
      bp_q   <= bp_d;
    end
  end

  assign bp_o = bp_q;

endmodule
`default_nettype wire

// ===== rtl/core/nonadjacent_subsequence_counter.sv =====
// Top level: counts non-adjacent subsequence matches of a pattern in a byte stream.
//
// Usage:
//   Program pattern_bytes (address 0, first character in the lowest byte) and
//   pattern_length (address 8) over the APB port while the block is idle.
//   Text bytes arrive on text_i; each accepted request yields exactly one
//   result on count_o: the count of ways the pattern occurs in the text so
//   far with no two chosen positions adjacent, saturating at 2^63-1.
//   end_of_text marks the last byte; its result carries final_flag and the
//   counts then restart from the empty text.
// Timing:
//   One byte per cycle while count_o does not stall. Each result is registered
//   in the output register in the cycle after acceptance. The chain of
//   MaxPattern cells updates every entry at once; the path is one 63-bit
//   saturating add per cell and the length-select mux.
// Reset:
//   Clears the pattern registers and all cell counts; no result is pending.
// Stall:
//   While a result waits, a new byte is taken only in the cycle in which
//   count_o.ready takes the waiting one.
`default_nettype none
module nonadjacent_subsequence_counter #(
  parameter int unsigned MaxPattern = nsc_pkg::MaxPatternDefault
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [nsc_pkg::PAddrW-1:0] paddr,
  input  wire logic [nsc_pkg::PDataW-1:0] pwdata,
  output logic      [nsc_pkg::PDataW-1:0] prdata,
  output logic                            pready,
  nsc_text_if.sink                        text_i,
  nsc_count_if.source                     count_o
);
  import nsc_pkg::*;

  localparam int unsigned SelW = $clog2(MaxPattern + 1);

  logic [PatternW-1:0] pattern_bytes;
  logic [LenW-1:0]     pattern_length;
  logic [SelW-1:0]     len_sel;
  cell_ctrl_t          ctrl;
  logic                step;

  logic [CountW-1:0] next_row [MaxPattern+1];
  logic [CountW-1:0] bp_row   [MaxPattern+1];

  logic              out_valid_q;
  logic [CountW-1:0] count_q;
  logic              final_q;

  nsc_cfg u_cfg (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .pattern_bytes_o  (pattern_bytes),
    .pattern_length_o (pattern_length)
  );

  assign text_i.ready = !out_valid_q || count_o.ready;
  assign step         = text_i.valid && text_i.ready;
  assign ctrl.step    = step;
  assign ctrl.clear   = step && text_i.end_of_text;

  // empty prefix always counts one
  assign next_row[0] = CountOne;
  assign bp_row[0]   = CountOne;

  for (genvar k = 0; k < MaxPattern; k++) begin : g_cell
    logic [ByteW-1:0] ch;
    if (k < PatternChars) begin : g_char
      assign ch = pattern_bytes[ByteW*k +: ByteW];
    end else begin : g_zero
      assign ch = '0;
    end

    nsc_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .byte_i    (text_i.text_byte),
      .char_i    (ch),
      .left_bp_i (bp_row[k]),
      .next_o    (next_row[k+1]),
      .bp_o      (bp_row[k+1])
    );
  end

  assign len_sel = (32'(pattern_length) > MaxPattern) ? SelW'(MaxPattern)
                                                      : SelW'(pattern_length);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (count_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      count_q <= next_row[len_sel];
      final_q <= text_i.end_of_text;
    end
  end

  assign count_o.valid       = out_valid_q;
  assign count_o.match_count = count_q;
  assign count_o.final_flag  = final_q;

  a_step_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_q)
    else $error("accepted byte did not produce a result");

  a_last_flags_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && text_i.end_of_text |=> final_q)
    else $error("last byte result not marked final");

  a_last_clears_cells: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && text_i.end_of_text |=> bp_row[MaxPattern] == '0)
    else $error("cells not cleared after end of text");

  a_empty_pattern_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && len_sel == '0 |=> count_q == CountOne)
    else $error("empty pattern must count one");

endmodule
`default_nettype wire

// ===== bench/nsc_count_checker.sv =====
// Checker for the subsequence counter: mirrors the registers, predicts counts, compares.
`timescale 1ns / 100ps
module nsc_count_checker #(
  parameter int unsigned MaxPattern = nsc_pkg::MaxPatternDefault
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic                       pready,
  input  wire logic [nsc_pkg::PAddrW-1:0] paddr,
  input  wire logic [nsc_pkg::PDataW-1:0] pwdata,
  nsc_text_if                             text_mon_i,
  nsc_count_if                            count_mon_i,
  output int unsigned                     fail_count_o,
  output int unsigned                     pending_o
);
  import nsc_pkg::*;

  typedef struct packed {
    logic [CountW-1:0] match_count;
    logic              final_flag;
  } count_rec_t;

  logic [PatternW-1:0] pattern_q;
  logic [LenW-1:0]     length_q;
  logic [CountW-1:0]   row_last  [MaxPattern+1];
  logic [CountW-1:0]   row_prior [MaxPattern+1];
  count_rec_t          expected_counts [$];
  count_rec_t          oldest;
  count_rec_t          fresh;

  function automatic void clear_rows();
    for (int j = 0; j <= MaxPattern; j++) begin
      row_last[j]  = (j == 0) ? CountOne : '0;
      row_prior[j] = (j == 0) ? CountOne : '0;
    end
  endfunction

  // One DP step over every prefix length; returns the count for the current length.
  function automatic logic [CountW-1:0] advance_rows(input logic [ByteW-1:0] ch);
    logic [CountW-1:0] next_row [MaxPattern+1];
    logic [CountW:0]   sum;
    logic [ByteW-1:0]  want_ch;
    int unsigned       used;
    next_row[0] = CountOne;
    for (int j = 1; j <= MaxPattern; j++) begin
      want_ch = (j - 1 < PatternChars) ? pattern_q[ByteW*(j-1) +: ByteW] : '0;
      sum = {1'b0, row_last[j]};
      if (ch == want_ch) begin
        sum = sum + {1'b0, row_prior[j-1]};
      end
      next_row[j] = (sum > {1'b0, CountMax}) ? CountMax : sum[CountW-1:0];
    end
    row_prior = row_last;
    row_last  = next_row;
    used = (length_q > MaxPattern) ? MaxPattern : length_q;
    return next_row[used];
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q = '0;
      length_q  = '0;
      clear_rows();
      expected_counts.delete();
      pending_o = 0;
    end else begin
      if (count_mon_i.valid && count_mon_i.ready) begin
        if (expected_counts.size() == 0) begin
          report_mismatch("unrequested result", 64'(count_mon_i.match_count), '0);
        end else begin
          oldest = expected_counts.pop_front();
          if (count_mon_i.match_count !== oldest.match_count) begin
            report_mismatch("match_count", 64'(count_mon_i.match_count),
                            64'(oldest.match_count));
          end
          if (count_mon_i.final_flag !== oldest.final_flag) begin
            report_mismatch("final_flag", 64'(count_mon_i.final_flag),
                            64'(oldest.final_flag));
          end
        end
      end
      if (text_mon_i.valid && text_mon_i.ready) begin
        fresh.match_count = advance_rows(text_mon_i.text_byte);
        fresh.final_flag  = text_mon_i.end_of_text;
        expected_counts.push_back(fresh);
        if (text_mon_i.end_of_text) begin
          clear_rows();
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr == {RegPatternBytes, 3'b000}) begin
          pattern_q = pwdata;
        end else if (paddr == {RegPatternLength, 3'b000}) begin
          length_q = pwdata[LenW-1:0];
        end
      end
      pending_o = expected_counts.size();
    end
  end

endmodule

// ===== bench/nonadjacent_subsequence_counter_tb.sv =====
// Testbench top for the subsequence counter: clock, reset, register writes, text stimulus.
`timescale 1ns / 100ps
module nonadjacent_subsequence_counter_tb;
  import nsc_pkg::*;

  localparam int unsigned CycleLimit = 200_000;
  localparam int unsigned ItemTarget = 1700;
  localparam int unsigned SatLength  = 1000;

  typedef enum int unsigned {
    StallNone,
    StallLight,
    StallHeavy,
    StallPeriodic
  } stall_e;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PAddrW-1:0] paddr;
  logic [PDataW-1:0] pwdata;
  logic [PDataW-1:0] prdata;
  logic              pready;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned items_sent;
  int unsigned burst_left;
  int unsigned hold_left;
  int unsigned cycle_count;
  bit          gap_enable;

  nsc_text_if  text_if ();
  nsc_count_if count_if ();

  nonadjacent_subsequence_counter u_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .text_i  (text_if),
    .count_o (count_if)
  );

  nsc_count_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .text_mon_i   (text_if),
    .count_mon_i  (count_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  // Result side: long hold-offs on request, otherwise a stall pattern that changes now and then.
  initial begin
    stall_e      stall_mode;
    int unsigned mode_left;
    int unsigned tick;
    stall_mode = StallNone;
    mode_left  = 0;
    tick       = 0;
    count_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        count_if.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode = stall_e'($urandom_range(0, 3));
          mode_left  = $urandom_range(50, 300);
        end
        mode_left--;
        case (stall_mode)
          StallNone:  count_if.ready <= 1'b1;
          StallLight: count_if.ready <= ($urandom_range(0, 3) != 0);
          StallHeavy: count_if.ready <= ($urandom_range(0, 3) == 0);
          default:    count_if.ready <= (tick % 3 != 0);
        endcase
      end
    end
  end

  task automatic send_text(input logic [ByteW-1:0] ch, input logic eot);
    int unsigned gap;
    @(negedge clk);
    text_if.valid       <= 1'b1;
    text_if.text_byte   <= ch;
    text_if.end_of_text <= eot;
    do @(posedge clk); while (!text_if.ready);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0 || !gap_enable) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        text_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // Stop offering bytes and wait until every count has come back.
  task automatic drain();
    @(negedge clk);
    text_if.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic apb_write(input reg_idx_e idx, input logic [PDataW-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic directed_part();
    // empty pattern after reset counts one
    send_text(8'h00, 1'b0);
    send_text(8'hFF, 1'b1);
    drain();
    apb_write(RegPatternBytes, {48'h0, 8'h62, 8'h61});
    apb_write(RegPatternLength, PDataW'(2));
    // first-character match at position zero, adjacent and non-adjacent pairs
    send_text(8'h61, 1'b0);
    send_text(8'h62, 1'b0);
    send_text(8'h61, 1'b0);
    send_text(8'h20, 1'b0);
    send_text(8'h62, 1'b0);
    send_text(8'h61, 1'b0);
    send_text(8'h62, 1'b1);
    drain();
    // all-ones pattern, length field above the maximum with junk in the upper bits
    apb_write(RegPatternBytes, '1);
    apb_write(RegPatternLength, '1);
    for (int i = 0; i < 15; i++) begin
      send_text(8'hFF, i == 14);
    end
    drain();
  endtask

  // Long run of one byte against a pattern of that byte: drives the counts into saturation.
  task automatic saturation_part();
    logic [ByteW-1:0] ch;
    ch = 8'($urandom_range(0, 255));
    apb_write(RegPatternBytes, {PatternChars{ch}});
    apb_write(RegPatternLength, PDataW'(MaxPatternDefault));
    for (int i = 0; i < SatLength; i++) begin
      send_text(ch, 1'b0);
    end
    // pattern changed mid-text
    drain();
    apb_write(RegPatternLength, PDataW'(3));
    for (int i = 0; i < 4; i++) begin
      send_text(ch, 1'b0);
    end
    drain();
    apb_write(RegPatternBytes, {{(PatternChars - 1){ch}}, ~ch});
    apb_write(RegPatternLength, PDataW'(MaxPatternDefault));
    send_text(ch, 1'b0);
    send_text(~ch, 1'b0);
    send_text(ch, 1'b1);
    drain();
  endtask

  task automatic random_phase(input int unsigned n_items);
    logic [ByteW-1:0]    base;
    logic [ByteW-1:0]    ch;
    logic [PatternW-1:0] pat;
    logic [PDataW-1:0]   len_word;
    bit                  set_pat;
    bit                  set_len;
    base = 8'($urandom_range(0, 255));
    for (int i = 0; i < PatternChars; i++) begin
      pat[ByteW*i +: ByteW] = 8'(base + $urandom_range(0, 2));
    end
    len_word = {$urandom, $urandom};
    len_word[LenW-1:0] = ($urandom_range(0, 9) == 0) ? LenW'($urandom_range(9, 15))
                                                     : LenW'($urandom_range(0, 8));
    set_pat = ($urandom_range(0, 3) != 0);
    set_len = ($urandom_range(0, 3) != 0);
    if (set_pat || set_len || $urandom_range(0, 3) == 0) begin
      drain();
    end
    if (set_pat) begin
      apb_write(RegPatternBytes, pat);
    end
    if (set_len) begin
      apb_write(RegPatternLength, len_word);
    end
    for (int i = 0; i < n_items; i++) begin
      ch = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                       : 8'(base + $urandom_range(0, 2));
      send_text(ch, $urandom_range(0, 24) == 0);
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    gap_enable = 1'b1;
    burst_left = 0;
    hold_left  = 0;
    text_if.valid       = 1'b0;
    text_if.text_byte   = '0;
    text_if.end_of_text = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    directed_part();
    saturation_part();

    // back-pressure: result side holds off while bytes keep coming
    drain();
    hold_left  = 300;
    gap_enable = 1'b0;
    random_phase(40);
    gap_enable = 1'b1;

    while (items_sent < ItemTarget) begin
      random_phase($urandom_range(20, 100));
    end

    drain();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
